>>> hw/rtl/ordered_list_engine_core_defines.svh
// assertion macros used by the checker file
`ifndef ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on the block clock, quiet during reset
`define OLE_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ole check failed");

// next-cycle implication, sampled on the block clock, quiet during reset
`define OLE_CHK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ole check failed");

`endif

>>> hw/rtl/ole_pkg.sv
package ole_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // shift command broadcast to every cell at the accepting edge
    typedef struct packed {
        logic ins;
        logic rem;
    } t_ole_shift;

    // flags of the probe that walks down the chain
    typedef struct packed {
        logic valid;
        logic srch;
        logic mod;
        logic hit;
    } t_ole_flags;

endpackage

>>> hw/rtl/ole_req_if.sv
interface ole_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  opcode;
    logic        [3:0]  position;
    logic signed [31:0] data_value;

    modport source (output valid, output opcode, output position, output data_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input data_value,
                    output ready);
endinterface

>>> hw/rtl/ole_rsp_if.sv
interface ole_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] old_word;
    logic               found;
    logic        [3:0]  found_position;
    logic        [4:0]  list_count;

    modport source (output valid, output status, output old_word, output found,
                    output found_position, output list_count, input ready);
    modport sink   (input valid, input status, input old_word, input found,
                    input found_position, input list_count, output ready);
endinterface

>>> hw/rtl/ole_cell.sv
module ole_cell #(
    parameter int WORD_BITS = 32,
    parameter int IW        = 4,
    parameter int PW        = 5,
    parameter int INDEX     = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  ole_pkg::t_ole_shift   i_shift,
    input  logic [PW-1:0]         i_pos,
    input  logic [PW-1:0]         i_count,
    input  logic [WORD_BITS-1:0]  i_data,
    input  logic [WORD_BITS-1:0]  i_left_word,
    input  logic [WORD_BITS-1:0]  i_right_word,
    output logic [WORD_BITS-1:0]  o_word,
    input  ole_pkg::t_ole_flags   i_flags,
    input  logic [WORD_BITS-1:0]  i_key,
    input  logic [IW-1:0]         i_where,
    input  logic [WORD_BITS-1:0]  i_old,
    output ole_pkg::t_ole_flags   o_flags,
    output logic [WORD_BITS-1:0]  o_key,
    output logic [IW-1:0]         o_where,
    output logic [WORD_BITS-1:0]  o_old
);
    import ole_pkg::*;

    localparam logic [PW-1:0] IDX   = PW'(INDEX);
    localparam logic [PW-1:0] IDX_1 = PW'(INDEX + 1);

    logic [WORD_BITS-1:0] r_word, n_word;
    t_ole_flags           r_flags, n_flags;
    logic [WORD_BITS-1:0] r_key;
    logic [IW-1:0]        r_where, n_where;
    logic [WORD_BITS-1:0] r_old, n_old;
    logic                 at_pos;

    assign at_pos = (IDX == i_pos);

    always_comb begin
        n_word = r_word;
        if (i_shift.ins) begin
            if (at_pos) begin
                n_word = i_data;
            end else if (IDX > i_pos && IDX <= i_count) begin
                n_word = i_left_word;
            end
        end else if (i_shift.rem) begin
            if (IDX >= i_pos && IDX_1 < i_count) begin
                n_word = i_right_word;
            end
        end else if (i_adv && i_flags.valid && i_flags.mod && at_pos) begin
            n_word = i_key;
        end
    end

    always_comb begin
        n_flags = i_flags;
        n_where = i_where;
        n_old   = i_old;
        if (i_flags.srch && !i_flags.hit && IDX < i_count && r_word == i_key) begin
            n_flags.hit = 1'b1;
            n_where     = IW'(INDEX);
        end
        if (i_flags.mod && at_pos) begin
            n_old = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_adv) begin
            r_flags <= n_flags;
        end
        if (i_adv) begin
            r_key   <= i_key;
            r_where <= n_where;
            r_old   <= n_old;
        end
    end

    assign o_word  = r_word;
    assign o_flags = r_flags;
    assign o_key   = r_key;
    assign o_where = r_where;
    assign o_old   = r_old;

endmodule

>>> hw/rtl/ordered_list_engine_core.sv
// positional list engine: a chain of CAPACITY cells, one list entry per cell
// i_req carries opcode, position and data_value; o_rsp returns one result per
// request transfer: status, old_word, found, found_position, list_count
// insert and remove shift every cell in parallel at the accepting edge;
// modify and search travel as a probe from cell 0 to the last cell, one cell
// per cycle while the chain is not frozen, so the probe walk sets the timing
// the result is registered into o_rsp when the probe leaves the last cell;
// no new request is taken while a probe is still in the chain;
// the next request is taken in the cycle the probe leaves the last cell
// i_rst_n (synchronous, active low) empties the list and drops any request in
// flight; list contents are not cleared, only positions below the count are read
// o_rsp has an output register, so a new request is taken while a result waits;
// if that result is still not taken when the next probe reaches the last cell,
// the chain freezes until the receiver takes it
module ordered_list_engine_core #(
    parameter int CAPACITY  = ole_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ole_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ole_req_if.sink   i_req,
    ole_rsp_if.source o_rsp
);
    import ole_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    // control state
    logic                 r_busy;
    logic [CW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_pos;
    logic [1:0]           r_status, n_status;

    // output register
    logic                 r_out_valid;
    logic [1:0]           r_o_status;
    logic [31:0]          r_o_old;
    logic                 r_o_found;
    logic [3:0]           r_o_fpos;
    logic [4:0]           r_o_count;

    logic                 accept;
    logic                 adv;
    logic                 last_done;
    logic [PW-1:0]        pos_in;
    logic [PW-1:0]        pos_bc;
    logic [PW-1:0]        cnt_x;
    t_ole_shift           shift;
    t_ole_flags           inj_flags;
    logic [WORD_BITS+31:0] data_ext;
    logic [WORD_BITS-1:0] key;

    // chain wiring, words padded with zero at both ends
    logic [WORD_BITS-1:0] w_word  [0:CAPACITY+1];
    t_ole_flags           w_flags [0:CAPACITY];
    logic [WORD_BITS-1:0] w_key   [0:CAPACITY];
    logic [IW-1:0]        w_where [0:CAPACITY];
    logic [WORD_BITS-1:0] w_old   [0:CAPACITY];

    logic [WORD_BITS+31:0] old_ext;
    logic [IW+3:0]         where_ext;
    logic [CW+4:0]         count_ext;

    // stored word is the low WORD_BITS of the request data
    assign data_ext = {{WORD_BITS{1'b0}}, i_req.data_value};
    assign key      = data_ext[WORD_BITS-1:0];

    assign last_done = w_flags[CAPACITY].valid;
    // freeze only when a finished probe meets an untaken result
    assign adv       = !(last_done && r_out_valid && !o_rsp.ready);
    assign i_req.ready = !r_busy || (last_done && adv);
    assign accept    = i_req.valid && i_req.ready;

    assign pos_in = PW'(i_req.position);
    assign cnt_x  = PW'(r_count);
    // modify position is live at the accepting edge and held afterwards
    assign pos_bc = accept ? pos_in : r_pos;

    // decode at the accepting edge
    always_comb begin
        shift     = '0;
        inj_flags = '0;
        n_status  = ST_OK;
        n_count   = r_count;
        if (accept) begin
            inj_flags.valid = 1'b1;
            unique case (i_req.opcode)
                OP_INSERT: begin
                    if (pos_in > cnt_x) begin
                        n_status = ST_RANGE;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        shift.ins = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
                OP_REMOVE: begin
                    if (pos_in >= cnt_x) begin
                        n_status = ST_RANGE;
                    end else begin
                        shift.rem = 1'b1;
                        n_count   = r_count - CW'(1);
                    end
                end
                OP_MODIFY: begin
                    if (pos_in >= cnt_x) begin
                        n_status = ST_RANGE;
                    end else begin
                        inj_flags.mod = 1'b1;
                    end
                end
                OP_SEARCH: begin
                    inj_flags.srch = 1'b1;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    assign w_word[0]          = '0;
    assign w_word[CAPACITY+1] = '0;
    assign w_flags[0]         = inj_flags;
    assign w_key[0]           = key;
    assign w_where[0]         = '0;
    assign w_old[0]           = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ole_cell #(
            .WORD_BITS (WORD_BITS),
            .IW        (IW),
            .PW        (PW),
            .INDEX     (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (adv),
            .i_shift      (shift),
            .i_pos        (pos_bc),
            .i_count      (cnt_x),
            .i_data       (key),
            .i_left_word  (w_word[g]),
            .i_right_word (w_word[g+2]),
            .o_word       (w_word[g+1]),
            .i_flags      (w_flags[g]),
            .i_key        (w_key[g]),
            .i_where      (w_where[g]),
            .i_old        (w_old[g]),
            .o_flags      (w_flags[g+1]),
            .o_key        (w_key[g+1]),
            .o_where      (w_where[g+1]),
            .o_old        (w_old[g+1])
        );
    end

    // fit chain results to the response field widths
    assign old_ext   = {32'b0, w_old[CAPACITY]};
    assign where_ext = {4'b0, w_where[CAPACITY]};
    assign count_ext = {5'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last_done && adv) begin
                r_busy <= 1'b0;
            end
            r_count <= n_count;
            if (last_done && adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_pos    <= pos_in;
            r_status <= n_status;
        end
        if (last_done && adv) begin
            r_o_status <= r_status;
            r_o_old    <= old_ext[31:0];
            r_o_found  <= w_flags[CAPACITY].hit;
            r_o_fpos   <= w_flags[CAPACITY].hit ? where_ext[3:0] : 4'd0;
            r_o_count  <= count_ext[4:0];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.old_word       = r_o_old;
    assign o_rsp.found          = r_o_found;
    assign o_rsp.found_position = r_o_fpos;
    assign o_rsp.list_count     = r_o_count;

endmodule

>>> hw/rtl/ole_checker.sv
`include "ordered_list_engine_core_defines.svh"

module ole_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_old_word,
    input logic        i_found,
    input logic [3:0]  i_found_position,
    input logic [4:0]  i_list_count
);
    import ole_pkg::*;

    // a stalled result holds
    `OLE_CHK_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_old_word) && $stable(i_found) && $stable(i_found_position) && $stable(i_list_count))

    // only the three defined status codes
    `OLE_CHK_IMP(a_status_code, i_rsp_valid, i_status == ST_OK || i_status == ST_RANGE || i_status == ST_FULL)

    // a hit or a returned word only on success, never both at once
    `OLE_CHK_IMP(a_payload_ok, i_rsp_valid && (i_found || i_old_word != 32'd0), i_status == ST_OK && !(i_found && i_old_word != 32'd0))

    // one request at a time while the probe walks the chain
    `OLE_CHK_NXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready)

endmodule

bind ordered_list_engine_core ole_checker u_ole_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_old_word       (o_rsp.old_word),
    .i_found          (o_rsp.found),
    .i_found_position (o_rsp.found_position),
    .i_list_count     (o_rsp.list_count)
);
